// ----- hw/rtl/quadratic_curve_flattener_unit_assert.svh -----
// Assertion macros shared by the curve flattener RTL.
`ifndef QUADRATIC_CURVE_FLATTENER_UNIT_ASSERT_SVH
`define QUADRATIC_CURVE_FLATTENER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QCF_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define QCF_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ----- hw/rtl/qcf_pkg.sv -----
// Shared types and constants of the quadratic curve flattener.
`default_nettype none
package qcf_pkg;

	localparam int LEVEL_BITS  = 3;
	localparam int LIMIT_BITS  = 12;
	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 12'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_POP
	} fsm_state_t;

	// Verdict on the half held in the work registers.
	typedef struct packed {
		logic is_top;   // depth 0: the whole curve, always split
		logic at_max;   // reached the depth limit, forced segment
		logic flat;     // control point close enough to the chord midpoint
	} node_status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/qcf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module qcf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [AW-1:0]        waddr,
	input  wire logic [WIDTH-1:0]     wdata,
	input  wire logic                 re,
	input  wire logic [AW-1:0]        raddr,
	output logic      [WIDTH-1:0]     rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ----- hw/rtl/qcf_split.sv -----
// Midpoint subdivision and flatness test of one curve half.
`default_nettype none
module qcf_split #(
	parameter int COORD_BITS = 12,
	parameter int MAX_DEPTH  = 6
) (
	input  wire logic signed [COORD_BITS-1:0]             start_x,
	input  wire logic signed [COORD_BITS-1:0]             start_y,
	input  wire logic signed [COORD_BITS-1:0]             control_x,
	input  wire logic signed [COORD_BITS-1:0]             control_y,
	input  wire logic signed [COORD_BITS-1:0]             end_x,
	input  wire logic signed [COORD_BITS-1:0]             end_y,
	input  wire logic        [qcf_pkg::LEVEL_BITS-1:0]    level,
	input  wire logic        [qcf_pkg::LIMIT_BITS-1:0]    limit,
	output logic signed      [COORD_BITS-1:0]             left_ctl_x,
	output logic signed      [COORD_BITS-1:0]             left_ctl_y,
	output logic signed      [COORD_BITS-1:0]             mid_x,
	output logic signed      [COORD_BITS-1:0]             mid_y,
	output logic signed      [COORD_BITS-1:0]             right_ctl_x,
	output logic signed      [COORD_BITS-1:0]             right_ctl_y,
	output qcf_pkg::node_status_t                         status
);
	localparam int CB  = COORD_BITS;
	localparam int LB  = qcf_pkg::LEVEL_BITS;
	localparam int DW  = CB + 2;
	localparam int CW  = (DW > qcf_pkg::LIMIT_BITS) ? DW : qcf_pkg::LIMIT_BITS;
	localparam logic [LB-1:0] MAX_LEVEL = LB'(MAX_DEPTH);

	// (a + b) / 2, rounding toward zero
	function automatic logic signed [CB-1:0] half(input logic signed [CB-1:0] a,
			input logic signed [CB-1:0] b);
		logic signed [CB:0] s;
		logic signed [CB:0] r;
		s = {a[CB-1], a} + {b[CB-1], b};
		r = s + {{CB{1'b0}}, s[CB]};
		half = r[CB:1];
	endfunction

	function automatic logic [CB:0] mag(input logic signed [CB:0] v);
		mag = v[CB] ? (-v) : v;
	endfunction

	logic signed [CB-1:0] chord_x, chord_y;
	logic signed [CB:0]   dev_x, dev_y;
	logic        [DW-1:0] dev;

	always_comb begin
		left_ctl_x  = half(start_x, control_x);
		left_ctl_y  = half(start_y, control_y);
		right_ctl_x = half(control_x, end_x);
		right_ctl_y = half(control_y, end_y);
		mid_x       = half(left_ctl_x, right_ctl_x);
		mid_y       = half(left_ctl_y, right_ctl_y);

		chord_x = half(start_x, end_x);
		chord_y = half(start_y, end_y);
		dev_x   = {control_x[CB-1], control_x} - {chord_x[CB-1], chord_x};
		dev_y   = {control_y[CB-1], control_y} - {chord_y[CB-1], chord_y};
		dev     = DW'(mag(dev_x)) + DW'(mag(dev_y));

		status.is_top = (level == '0);
		status.at_max = (level >= MAX_LEVEL);
		status.flat   = (CW'(dev) <= CW'(limit));
	end

endmodule
`default_nettype wire

// ----- hw/rtl/quadratic_curve_flattener_unit.sv -----
// Top level of the quadratic curve flattener: sequencer, work registers, stack.
//
// Usage:
//   A curve request (start, control, end point) enters on in_valid/in_ready.
//   in_ready is high only while no curve is being flattened. The block emits
//   line segments on out_valid/out_ready, left to right along the curve; the
//   final segment of a curve has last_segment set.
//   flatness_limit is written on cfg_valid/cfg_ready between curves (cfg_ready
//   is high whenever the block is idle); it resets to 3.
//   Sequencing: each subdivision node, split or emitted, is handled in
//   ST_EVAL; each stack pop adds a pass through ST_POP, which waits on the
//   registered stack RAM read. A curve with S splits has S+1 segments and S
//   pops; the whole curve is always split, and at MAX_DEPTH = 6 there are at
//   most 63 splits and 64 segments. in_ready returns the cycle after the final
//   segment is emitted.
//   Stall: the segment output register holds its request until taken; while
//   it is full and out_ready is low, the sequencer waits on the next segment.
//   A new curve may be accepted while the last segment still waits.
//   Reset (arst_n low, asynchronous) returns to idle, drops any pending
//   segment and reloads the limit. The stack RAM needs no clearing: each
//   entry is written before it is read within the same curve.
`default_nettype none
module quadratic_curve_flattener_unit #(
	parameter int COORD_BITS = 12,
	parameter int MAX_DEPTH  = 6
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// configuration write channel
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic        [qcf_pkg::LIMIT_BITS-1:0] flatness_limit,
	// curve input channel
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic signed [COORD_BITS-1:0]          start_x,
	input  wire logic signed [COORD_BITS-1:0]          start_y,
	input  wire logic signed [COORD_BITS-1:0]          control_x,
	input  wire logic signed [COORD_BITS-1:0]          control_y,
	input  wire logic signed [COORD_BITS-1:0]          end_x,
	input  wire logic signed [COORD_BITS-1:0]          end_y,
	// segment output channel
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic signed      [COORD_BITS-1:0]          seg_from_x,
	output logic signed      [COORD_BITS-1:0]          seg_from_y,
	output logic signed      [COORD_BITS-1:0]          seg_to_x,
	output logic signed      [COORD_BITS-1:0]          seg_to_y,
	output logic                                       last_segment
);
	localparam int CB   = COORD_BITS;
	localparam int LB   = qcf_pkg::LEVEL_BITS;
	localparam int AW   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int NB   = $clog2(MAX_DEPTH + 1);
	localparam int WW   = 6 * CB + LB;
	localparam logic [NB-1:0] MAX_COUNT = NB'(MAX_DEPTH);
	localparam logic [LB-1:0] MAX_LEVEL = LB'(MAX_DEPTH);

	qcf_pkg::fsm_state_t state_q, state_d;

	logic [qcf_pkg::LIMIT_BITS-1:0] limit_q;

	// half under examination
	logic signed [CB-1:0] work_sx_q, work_sy_q, work_cx_q, work_cy_q, work_ex_q, work_ey_q;
	logic        [LB-1:0] work_level_q;
	logic        [NB-1:0] count_q;

	// segment output register
	logic                 out_valid_q;
	logic signed [CB-1:0] seg_fx_q, seg_fy_q, seg_tx_q, seg_ty_q;
	logic                 seg_last_q;

	logic signed [CB-1:0] lc_x, lc_y, m_x, m_y, rc_x, rc_y;
	qcf_pkg::node_status_t node;

	logic          do_split, do_emit, out_free, accept, cfg_write;
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [WW-1:0] ram_wdata, ram_rdata;
	logic [LB-1:0] next_level;

	qcf_split #(
		.COORD_BITS (COORD_BITS),
		.MAX_DEPTH  (MAX_DEPTH)
	) u_split (
		.start_x     (work_sx_q),
		.start_y     (work_sy_q),
		.control_x   (work_cx_q),
		.control_y   (work_cy_q),
		.end_x       (work_ex_q),
		.end_y       (work_ey_q),
		.level       (work_level_q),
		.limit       (limit_q),
		.left_ctl_x  (lc_x),
		.left_ctl_y  (lc_y),
		.mid_x       (m_x),
		.mid_y       (m_y),
		.right_ctl_x (rc_x),
		.right_ctl_y (rc_y),
		.status      (node)
	);

	// stack of right halves still to visit
	qcf_ram #(
		.WIDTH (WW),
		.DEPTH (MAX_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign next_level = work_level_q + LB'(1);
	assign out_free   = !out_valid_q || out_ready;
	assign accept     = in_valid && in_ready;
	assign cfg_write  = cfg_valid && cfg_ready;

	// right half: mid point, right control, current end
	assign ram_wdata = {m_x, m_y, rc_x, rc_y, work_ex_q, work_ey_q, next_level};
	assign ram_waddr = count_q[AW-1:0];
	assign ram_raddr = AW'(count_q - NB'(1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			qcf_pkg::ST_IDLE: begin
				if (in_valid) state_d = qcf_pkg::ST_EVAL;
			end
			qcf_pkg::ST_EVAL: begin
				if (do_emit) begin
					state_d = (count_q == '0) ? qcf_pkg::ST_IDLE : qcf_pkg::ST_POP;
				end
			end
			qcf_pkg::ST_POP: begin
				state_d = qcf_pkg::ST_EVAL;
			end
			default: state_d = qcf_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready  = 1'b0;
		cfg_ready = 1'b0;
		do_split  = 1'b0;
		do_emit   = 1'b0;
		unique case (state_q)
			qcf_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				cfg_ready = 1'b1;
			end
			qcf_pkg::ST_EVAL: begin
				// the whole curve is always split; the deepest halves never are
				do_split = node.is_top || (!node.at_max && !node.flat);
				do_emit  = !do_split && out_free;
			end
			qcf_pkg::ST_POP: begin
			end
			default: begin
			end
		endcase
		ram_we = do_split;
		ram_re = do_emit && (count_q != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= qcf_pkg::ST_IDLE;
			limit_q     <= qcf_pkg::LIMIT_RESET;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write) limit_q <= flatness_limit;
			if (accept) begin
				count_q <= '0;
			end else if (do_split) begin
				count_q <= count_q + NB'(1);
			end else if (ram_re) begin
				count_q <= count_q - NB'(1);
			end
			if (do_emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// work registers and segment payload
	always_ff @(posedge clk) begin
		if (accept) begin
			work_sx_q    <= start_x;
			work_sy_q    <= start_y;
			work_cx_q    <= control_x;
			work_cy_q    <= control_y;
			work_ex_q    <= end_x;
			work_ey_q    <= end_y;
			work_level_q <= '0;
		end else if (do_split) begin
			// left half: same start, left control, mid point
			work_cx_q    <= lc_x;
			work_cy_q    <= lc_y;
			work_ex_q    <= m_x;
			work_ey_q    <= m_y;
			work_level_q <= next_level;
		end else if (state_q == qcf_pkg::ST_POP) begin
			{work_sx_q, work_sy_q, work_cx_q, work_cy_q, work_ex_q, work_ey_q,
				work_level_q} <= ram_rdata;
		end
		if (do_emit) begin
			seg_fx_q   <= work_sx_q;
			seg_fy_q   <= work_sy_q;
			seg_tx_q   <= work_ex_q;
			seg_ty_q   <= work_ey_q;
			seg_last_q <= (count_q == '0);
		end
	end

	assign out_valid    = out_valid_q;
	assign seg_from_x   = seg_fx_q;
	assign seg_from_y   = seg_fy_q;
	assign seg_to_x     = seg_tx_q;
	assign seg_to_y     = seg_ty_q;
	assign last_segment = seg_last_q;

	`include "quadratic_curve_flattener_unit_assert.svh"

	`QCF_ASSERT_IMP(a_stack_bound, clk, arst_n, 1'b1, count_q <= MAX_COUNT,
		"stack count beyond depth")
	`QCF_ASSERT_IMP(a_level_bound, clk, arst_n, state_q == qcf_pkg::ST_EVAL,
		work_level_q <= MAX_LEVEL, "work level beyond depth")
	`QCF_ASSERT_IMP(a_no_push_full, clk, arst_n, do_split, count_q < MAX_COUNT,
		"push onto full stack")
	`QCF_ASSERT_NXT(a_last_ends, clk, arst_n, do_emit && count_q == '0,
		state_q == qcf_pkg::ST_IDLE && out_valid_q && seg_last_q,
		"final segment did not end the curve")
	`QCF_ASSERT_NXT(a_accept_top, clk, arst_n, accept,
		state_q == qcf_pkg::ST_EVAL && work_level_q == '0 && count_q == '0,
		"curve did not start at depth zero")

endmodule
`default_nettype wire
